### rtl/acf_pkg.sv
// Shared types, constants and helper functions of the attitude filter.
package acf_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int CordicIters = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int DivSteps = 64;

   localparam logic [1:0] OP_MUL = 2'd0;
   localparam logic [1:0] OP_DIV = 2'd1;
   localparam logic [1:0] OP_COR = 2'd2;

   localparam logic [1:0] GR_250 = 2'd0;
   localparam logic [1:0] GR_500 = 2'd1;
   localparam logic [1:0] GR_1000 = 2'd2;

   localparam logic signed [31:0] DEG180_Q16 = 32'sd11796480;

   typedef struct packed {
      logic              start;
      logic [1:0]        op;
      logic [63:0]       opa;
      logic [31:0]       opb;
      logic signed [15:0] cy;
      logic signed [15:0] cx;
   } acf_cmd_type;

   typedef struct packed {
      logic              done;
      logic [63:0]       res;
      logic signed [31:0] ang;
   } acf_sts_type;

   // dt times the numerator of the full-scale ratio
   function automatic logic [26:0] range_dt(input logic [1:0] r, input logic [23:0] dt);
      case (r)
         GR_250: return 27'(dt);
         GR_500: return 27'(dt) << 1;
         default: return (27'(dt) << 2) + 27'(dt);
      endcase
   endfunction

   function automatic logic [7:0] range_div(input logic [1:0] r);
      case (r)
         GR_250: return 8'd131;
         GR_500: return 8'd131;
         GR_1000: return 8'd164;
         default: return 8'd82;
      endcase
   endfunction

   // atan(2^-i) in Q16.16 degrees
   function automatic logic signed [31:0] atan_q16(input logic [4:0] i);
      case (i)
         5'd0: return 32'sd2949120;
         5'd1: return 32'sd1740967;
         5'd2: return 32'sd919879;
         5'd3: return 32'sd466945;
         5'd4: return 32'sd234379;
         5'd5: return 32'sd117304;
         5'd6: return 32'sd58666;
         5'd7: return 32'sd29335;
         5'd8: return 32'sd14668;
         5'd9: return 32'sd7334;
         5'd10: return 32'sd3667;
         5'd11: return 32'sd1833;
         5'd12: return 32'sd917;
         5'd13: return 32'sd458;
         5'd14: return 32'sd229;
         5'd15: return 32'sd115;
         5'd16: return 32'sd57;
         5'd17: return 32'sd29;
         5'd18: return 32'sd14;
         5'd19: return 32'sd7;
         5'd20: return 32'sd4;
         5'd21: return 32'sd2;
         5'd22: return 32'sd1;
         default: return 32'sd0;
      endcase
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

### rtl/acf_iter_unit.sv
// Shared iterative unit: shift-add multiply, restoring divide, CORDIC vectoring.
module acf_iter_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  acf_pkg::acf_cmd_type cmd,
   output acf_pkg::acf_sts_type sts
);
   import acf_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [1:0]        op_ff, op_in;
   logic [63:0]       ra_ff, ra_in;
   logic [63:0]       rb_ff, rb_in;
   logic [31:0]       rc_ff, rc_in;
   logic [16:0]       rem_ff, rem_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic signed [35:0] x_ff, x_in;
   logic signed [35:0] y_ff, y_in;
   logic signed [31:0] z_ff, z_in;

   logic [63:0]       add_a, add_b;
   logic              add_sub;
   logic [64:0]       add_res;
   logic [16:0]       rem_sh;
   logic              ge;
   logic signed [35:0] cx36, cy36, xs, ys;

   assign rem_sh = {rem_ff[15:0], ra_ff[63]};
   assign add_sub = (op_ff == OP_DIV);
   assign add_a = add_sub ? 64'(rem_sh) : ra_ff;
   assign add_b = add_sub ? 64'(rc_ff) : rb_ff;
   assign add_res = add_sub ? ({1'b0, add_a} - {1'b0, add_b})
                            : ({1'b0, add_a} + {1'b0, add_b});
   assign ge = ~add_res[64];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      ra_in = ra_ff;
      rb_in = rb_ff;
      rc_in = rc_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      cx36 = 36'(cmd.cx);
      cy36 = 36'(cmd.cy);
      xs = x_ff >>> cnt_ff[4:0];
      ys = y_ff >>> cnt_ff[4:0];

      if (!busy_ff) begin
         if (cmd.start) begin
            busy_in = 1'b1;
            op_in = cmd.op;
            cnt_in = '0;
            rem_in = '0;
            rc_in = cmd.opb;
            case (cmd.op)
               OP_MUL: begin
                  ra_in = '0;
                  rb_in = cmd.opa;
               end
               OP_DIV: begin
                  ra_in = cmd.opa;
               end
               default: begin
                  z_in = '0;
                  if (cmd.cx < 0) begin
                     z_in = (cmd.cy >= 0) ? DEG180_Q16 : -DEG180_Q16;
                     cx36 = -cx36;
                     cy36 = -cy36;
                  end
                  x_in = cx36 <<< 16;
                  y_in = cy36 <<< 16;
               end
            endcase
         end
      end else begin
         case (op_ff)
            OP_MUL: begin
               if (rc_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  if (rc_ff[0]) begin
                     ra_in = add_res[63:0];
                  end
                  rb_in = rb_ff << 1;
                  rc_in = rc_ff >> 1;
               end
            end
            OP_DIV: begin
               rem_in = ge ? add_res[16:0] : rem_sh;
               ra_in = {ra_ff[62:0], ge};
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff == 7'(DivSteps - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
            default: begin
               if (y_ff > 0) begin
                  x_in = x_ff + ys;
                  y_in = y_ff - xs;
                  z_in = z_ff + atan_q16(cnt_ff[4:0]);
               end else if (y_ff < 0) begin
                  x_in = x_ff - ys;
                  y_in = y_ff + xs;
                  z_in = z_ff - atan_q16(cnt_ff[4:0]);
               end
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff == 7'(CordicIters - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff <= OP_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff <= op_in;
      end
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      rc_ff <= rc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign sts.done = done_ff;
   assign sts.res = ra_ff;
   assign sts.ang = z_ff;

endmodule

### rtl/imu_complementary_attitude_filter_top.sv
// Top level of the complementary-filter attitude estimator.
// One item at a time goes through a shared multiply/divide/CORDIC unit. A calibration
// item adds one gyro sample to the sums; the item that closes a run also does three
// 64-step divides for the offsets. An attitude item does, per gyro axis, a shift-add
// multiply by dt and a 64-step divide, then two 16-step CORDIC runs and two blend
// multiplies by tau. The 64-step divides take the largest share of an attitude item.
// A finished result waits in the output register while the next item is taken.
module imu_complementary_attitude_filter_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_command,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_roll_out,
   output logic signed [31:0] rsp_pitch_out,
   output logic signed [31:0] rsp_yaw_out,
   output logic               rsp_offsets_ready,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);
   import acf_pkg::*;

   localparam logic [1:0] CSR_GYRO_RANGE = 2'd0;
   localparam logic [1:0] CSR_BLEND = 2'd1;
   localparam logic [1:0] CSR_PERIOD = 2'd2;
   localparam logic [1:0] CSR_CAL_COUNT = 2'd3;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_CAL = 4'd1;
   localparam logic [3:0] ST_CDIV = 4'd2;
   localparam logic [3:0] ST_GMUL = 4'd3;
   localparam logic [3:0] ST_GDIV = 4'd4;
   localparam logic [3:0] ST_CORP = 4'd5;
   localparam logic [3:0] ST_CORR = 4'd6;
   localparam logic [3:0] ST_BLR = 4'd7;
   localparam logic [3:0] ST_BLP = 4'd8;
   localparam logic [3:0] ST_OUT = 4'd9;

   logic [1:0]  range_ff;
   logic [16:0] blend_ff;
   logic [23:0] period_ff;
   logic [15:0] count_ff;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  axis_ff, axis_in;
   logic        issued_ff, issued_in;
   logic        sign_ff, sign_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic signed [15:0] g_ff [3];
   logic signed [32:0] sums_ff [3];
   logic signed [32:0] sums_in [3];
   logic signed [31:0] offs_ff [3];
   logic signed [31:0] offs_in [3];
   logic signed [33:0] dlt_ff [3];
   logic signed [33:0] dlt_in [3];
   logic [15:0] prog_ff, prog_in;
   logic        done_ff, done_in;
   logic signed [31:0] roll_ff, roll_in, pitch_ff, pitch_in, yaw_ff, yaw_in;
   logic signed [31:0] accp_ff, accp_in, accr_ff, accr_in;

   logic signed [31:0] out_roll_ff, out_pitch_ff, out_yaw_ff;
   logic        out_ready_ff;

   acf_cmd_type u_cmd;
   acf_sts_type u_sts;

   logic [15:0] n_eff, p1;
   logic [16:0] tau_sat;
   logic signed [15:0] g_sel;
   logic signed [31:0] off_sel;
   logic signed [33:0] corr;
   logic [33:0] corr_mag;
   logic [26:0] dtm;
   logic [7:0]  gdiv;
   logic [63:0] grnd, gdvd;
   logic signed [33:0] dq;
   logic signed [32:0] sum_sel;
   logic [32:0] sum_mag;
   logic [63:0] cdvd;
   logic signed [31:0] calsat;
   logic signed [34:0] gp;
   logic signed [31:0] acc_sel;
   logic signed [35:0] diff;
   logic [35:0] diff_mag;
   logic signed [63:0] psg, bl, bls;
   logic signed [31:0] blend_val;
   logic signed [34:0] ysum;
   logic        load_out;

   acf_iter_unit u_unit (
      .clock(clock),
      .reset(reset),
      .cmd(u_cmd),
      .sts(u_sts)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign load_out = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      n_eff = (count_ff == '0) ? 16'd1 : count_ff;
      tau_sat = (blend_ff > 17'd65536) ? 17'd65536 : blend_ff;
      g_sel = g_ff[axis_ff];
      off_sel = offs_ff[axis_ff];
      corr = $signed({{2{g_sel[15]}}, g_sel, 16'h0000}) - 34'(off_sel);
      corr_mag = corr[33] ? 34'(-corr) : 34'(corr);
      dtm = range_dt(range_ff, period_ff);
      gdiv = range_div(range_ff);
      grnd = u_sts.res + (64'(gdiv) << 23);
      gdvd = grnd >> 24;
      dq = sign_ff ? -$signed(u_sts.res[33:0]) : $signed(u_sts.res[33:0]);
      sum_sel = sums_ff[axis_ff];
      sum_mag = sum_sel[32] ? 33'(-sum_sel) : 33'(sum_sel);
      cdvd = {15'b0, sum_mag, 16'h0000} + 64'(n_eff >> 1);
      if (sign_ff) begin
         calsat = (u_sts.res > 64'h80000000) ? 32'sh80000000 : -$signed(u_sts.res[31:0]);
      end else begin
         calsat = (u_sts.res > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(u_sts.res[31:0]);
      end
      if (state_ff == ST_BLR) begin
         gp = 35'(roll_ff) - 35'(dlt_ff[1]);
         acc_sel = accr_ff;
      end else begin
         gp = 35'(pitch_ff) + 35'(dlt_ff[0]);
         acc_sel = accp_ff;
      end
      diff = 36'(gp) - 36'(acc_sel);
      diff_mag = diff[35] ? 36'(-diff) : 36'(diff);
      psg = sign_ff ? -$signed(u_sts.res) : $signed(u_sts.res);
      bl = psg + ($signed(64'(acc_sel)) <<< 16) + 64'sd32768;
      bls = bl >>> 16;
      blend_val = sat32(bls);
      ysum = 35'(yaw_ff) + 35'(dlt_ff[2]);
      p1 = prog_ff + 16'd1;

      u_cmd.start = !issued_ff && (state_ff inside {ST_CDIV, ST_GMUL, ST_GDIV, ST_CORP,
                                                    ST_CORR, ST_BLR, ST_BLP});
      u_cmd.op = OP_MUL;
      u_cmd.opa = 64'(diff_mag);
      u_cmd.opb = 32'(tau_sat);
      u_cmd.cy = ay_ff;
      u_cmd.cx = az_ff;
      case (state_ff)
         ST_CDIV: begin
            u_cmd.op = OP_DIV;
            u_cmd.opa = cdvd;
            u_cmd.opb = 32'(n_eff);
         end
         ST_GMUL: begin
            u_cmd.opa = 64'(corr_mag);
            u_cmd.opb = 32'(dtm);
         end
         ST_GDIV: begin
            u_cmd.op = OP_DIV;
            u_cmd.opa = gdvd;
            u_cmd.opb = 32'(gdiv);
         end
         ST_CORP: u_cmd.op = OP_COR;
         ST_CORR: begin
            u_cmd.op = OP_COR;
            u_cmd.cy = ax_ff;
         end
         default: ;
      endcase

      state_in = state_ff;
      axis_in = axis_ff;
      issued_in = issued_ff;
      sign_in = sign_ff;
      sums_in = sums_ff;
      offs_in = offs_ff;
      dlt_in = dlt_ff;
      prog_in = prog_ff;
      done_in = done_ff;
      roll_in = roll_ff;
      pitch_in = pitch_ff;
      yaw_in = yaw_ff;
      accp_in = accp_ff;
      accr_in = accr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end

      if (u_cmd.start) begin
         issued_in = 1'b1;
         case (state_ff)
            ST_CDIV: sign_in = sum_sel[32];
            ST_GMUL: sign_in = corr[33];
            ST_BLR, ST_BLP: sign_in = diff[35];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_command ? ST_GMUL : ST_CAL;
               axis_in = '0;
               issued_in = 1'b0;
            end
         end
         ST_CAL: begin
            for (int k = 0; k < 3; k++) begin
               sums_in[k] = sums_ff[k] + 33'(g_ff[k]);
            end
            prog_in = p1;
            state_in = (p1 >= n_eff) ? ST_CDIV : ST_OUT;
         end
         ST_OUT: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            if (u_sts.done) begin
               issued_in = 1'b0;
               case (state_ff)
                  ST_CDIV: begin
                     offs_in[axis_ff] = calsat;
                     sums_in[axis_ff] = '0;
                     if (axis_ff == 2'd2) begin
                        prog_in = '0;
                        done_in = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        axis_in = axis_ff + 2'd1;
                     end
                  end
                  ST_GMUL: state_in = ST_GDIV;
                  ST_GDIV: begin
                     dlt_in[axis_ff] = dq;
                     if (axis_ff == 2'd2) begin
                        state_in = ST_CORP;
                     end else begin
                        axis_in = axis_ff + 2'd1;
                        state_in = ST_GMUL;
                     end
                  end
                  ST_CORP: begin
                     accp_in = u_sts.ang;
                     state_in = ST_CORR;
                  end
                  ST_CORR: begin
                     accr_in = u_sts.ang;
                     state_in = ST_BLR;
                  end
                  ST_BLR: begin
                     roll_in = blend_val;
                     state_in = ST_BLP;
                  end
                  default: begin
                     pitch_in = blend_val;
                     yaw_in = sat32(64'(ysum));
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= 2'd1;
         blend_ff <= 17'd64225;
         period_ff <= 24'd167772;
         count_ff <= 16'd1000;
         state_ff <= ST_IDLE;
         axis_ff <= '0;
         issued_ff <= 1'b0;
         sign_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            sums_ff[k] <= '0;
            offs_ff[k] <= '0;
         end
         prog_ff <= '0;
         done_ff <= 1'b0;
         roll_ff <= '0;
         pitch_ff <= '0;
         yaw_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GYRO_RANGE: range_ff <= csr_wdata[1:0];
               CSR_BLEND: blend_ff <= csr_wdata[16:0];
               CSR_PERIOD: period_ff <= csr_wdata;
               CSR_CAL_COUNT: count_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         state_ff <= state_in;
         axis_ff <= axis_in;
         issued_ff <= issued_in;
         sign_ff <= sign_in;
         rsp_valid_ff <= rsp_valid_in;
         sums_ff <= sums_in;
         offs_ff <= offs_in;
         prog_ff <= prog_in;
         done_ff <= done_in;
         roll_ff <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff <= yaw_in;
      end
      dlt_ff <= dlt_in;
      accp_ff <= accp_in;
      accr_ff <= accr_in;
      if (state_ff == ST_IDLE && req_valid) begin
         ax_ff <= req_accel_x;
         ay_ff <= req_accel_y;
         az_ff <= req_accel_z;
         g_ff[0] <= req_gyro_x;
         g_ff[1] <= req_gyro_y;
         g_ff[2] <= req_gyro_z;
      end
      if (load_out) begin
         out_roll_ff <= roll_ff;
         out_pitch_ff <= pitch_ff;
         out_yaw_ff <= yaw_ff;
         out_ready_ff <= done_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_roll_out = out_roll_ff;
   assign rsp_pitch_out = out_pitch_ff;
   assign rsp_yaw_out = out_yaw_ff;
   assign rsp_offsets_ready = out_ready_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside the output state");

   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      u_sts.done |-> issued_ff)
      else $error("unit finished without an issued operation");

   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("offsets ready flag dropped");

endmodule
